// ===== hdl/sld_pkg.sv =====
`default_nettype none

package sld_pkg;

	localparam int HDR_DEPTH = 16;
	localparam int HDR_IDX_W = $clog2(HDR_DEPTH);
	localparam logic [7:0] FRAME_LIMIT = 8'd128;
	localparam logic [8:0] LEN_OFFSET = 9'd8;
	localparam logic [7:0] COUNT_AT_START = 8'd2;
	localparam logic [7:0] LEN_POS = 8'd3;

	localparam logic [7:0] SYNC0 = 8'h55;
	localparam logic [7:0] SYNC1 = 8'hAA;
	localparam logic [7:0] MOD_VOLT = 8'h01;
	localparam logic [7:0] MOD_IO = 8'h06;
	localparam logic [7:0] MOD_ANALOG = 8'h07;
	localparam logic [7:0] MOD_MOTOR = 8'h08;
	localparam logic [7:0] METH_CHASSIS = 8'h60;
	localparam logic [7:0] METH_JOINT = 8'h63;
	localparam logic [7:0] CHASSIS_ID_LO = 8'd1;
	localparam logic [7:0] CHASSIS_ID_HI = 8'd4;
	localparam logic [7:0] JOINT_ID_LO = 8'd11;
	localparam logic [7:0] JOINT_ID_HI = 8'd15;

	localparam logic [2:0] KIND_VOLT = 3'd0;
	localparam logic [2:0] KIND_IO = 3'd1;
	localparam logic [2:0] KIND_ANALOG = 3'd2;
	localparam logic [2:0] KIND_CHASSIS = 3'd3;
	localparam logic [2:0] KIND_JOINT = 3'd4;

	localparam logic [1:0] LAST_CHANNEL = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One decoded frame: kind, unit and the payload bytes it needs.
	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  unit;
		logic [63:0] data;
	} frame_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sync_length_frame_decoder_unit.sv =====
// Deframer for a serial byte stream with a 0x55 0xAA sync pair and a length byte.
// Receive channel: rx_valid / rx_stall carry one rx_byte per transaction; a
// transaction completes on a rising edge with rx_valid high and rx_stall low.
// Result channel: res_valid / res_stall carry kind, unit, value_a, value_b and
// last; last marks the final result caused by one received byte.
// Throughput: one byte per cycle in while the queue has room, one result per
// cycle out while res_stall is low. An analog frame yields four results, one
// per channel, other frames one or none. A frame's descriptor enters the queue
// at the edge that accepts its final byte; the output register loads it once it
// heads the queue and the register is empty or res_stall is low.
// A two-entry descriptor queue parts the front from the output side; rx_stall
// rises only while that queue is full, so a stalled receiver holds the output
// register and, once two decoded frames wait behind it, holds the input too.
// Reset (arst_n low) clears the frame state, the sixteen-byte header store,
// the queue and the output valid at once; the block is ready on the first edge.
`default_nettype none

module sync_length_frame_decoder_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                rx_valid,
	output logic               rx_stall,
	input  wire [7:0]          rx_byte,
	output logic               res_valid,
	input  wire                res_stall,
	output logic [2:0]         kind,
	output logic [2:0]         unit,
	output logic signed [31:0] value_a,
	output logic signed [31:0] value_b,
	output logic               last
);
	import sld_pkg::*;

	logic        rx_accept;
	logic        q_push;
	logic        q_pop;
	frame_desc_t front_desc;
	frame_desc_t q_head;
	q_stat_t     q_stat;

	// Hold the input only while the queue has no room for a decoded frame.
	assign rx_stall = q_stat.full;
	assign rx_accept = rx_valid && !rx_stall;

	sld_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (rx_accept),
		.rx_byte (rx_byte),
		.push    (q_push),
		.desc    (front_desc)
	);

	sld_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_desc (front_desc),
		.pop     (q_pop),
		.head    (q_head),
		.stat    (q_stat)
	);

	// Expand each descriptor into its results and drive the output register.
	sld_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.stat      (q_stat),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.unit      (unit),
		.value_a   (value_a),
		.value_b   (value_b),
		.last      (last)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("descriptor pushed into a full queue");

	a_only_analog_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last |-> kind == KIND_ANALOG)
		else $error("non-final result of a single-result frame");

	a_analog_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last && kind == KIND_ANALOG |-> unit == 3'd3)
		else $error("analog frame closed before its fourth channel");

	a_analog_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last |=> res_valid && kind == KIND_ANALOG)
		else $error("analog frame results interrupted");
`endif

endmodule

`default_nettype wire

// ===== hdl/sld_front.sv =====
`default_nettype none

module sld_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire [7:0]            rx_byte,
	output logic                 push,
	output sld_pkg::frame_desc_t desc
);
	import sld_pkg::*;

	logic                 in_frame_q;
	logic [7:0]           prev_q;
	logic [7:0]           count_q;
	logic [8:0]           len_q;
	logic [7:0]           hb_q [HDR_DEPTH];

	logic                 in_frame_n;
	logic [7:0]           prev_n;
	logic [7:0]           count_n;
	logic [8:0]           len_n;
	logic [7:0]           hb_n [HDR_DEPTH];
	logic                 start;
	logic                 done;
	logic                 dec_ok;

	always_comb begin
		hb_n = hb_q;
		if (count_q < 8'(HDR_DEPTH)) begin
			hb_n[count_q[HDR_IDX_W-1:0]] = rx_byte;
		end
		in_frame_n = in_frame_q;
		prev_n = prev_q;
		count_n = count_q;
		len_n = len_q;
		done = 1'b0;
		start = !in_frame_q && (prev_q == SYNC0) && (rx_byte == SYNC1);
		if (start) begin
			hb_n[0] = SYNC0;
			hb_n[1] = SYNC1;
			in_frame_n = 1'b1;
			count_n = COUNT_AT_START;
			prev_n = 8'd0;
		end else if (in_frame_q) begin
			if (count_q == LEN_POS) begin
				len_n = {1'b0, rx_byte} + LEN_OFFSET;
			end
			count_n = count_q + 8'd1;
			done = ({1'b0, count_n} == len_n);
			if (done || (count_n >= FRAME_LIMIT)) begin
				in_frame_n = 1'b0;
			end
		end else begin
			prev_n = rx_byte;
		end
	end

	// Classify the completed frame from the store as it stands after this byte.
	always_comb begin
		dec_ok = 1'b0;
		desc.kind = KIND_VOLT;
		desc.unit = 3'd0;
		desc.data = 64'd0;
		case (hb_n[4])
			MOD_VOLT: begin
				dec_ok = 1'b1;
				desc.data[15:0] = {hb_n[7], hb_n[8]};
			end
			MOD_IO: begin
				dec_ok = 1'b1;
				desc.kind = KIND_IO;
				desc.data[3:0] = hb_n[8][3:0];
			end
			MOD_ANALOG: begin
				dec_ok = 1'b1;
				desc.kind = KIND_ANALOG;
				desc.data = {hb_n[7], hb_n[8], hb_n[9], hb_n[10],
					hb_n[11], hb_n[12], hb_n[13], hb_n[14]};
			end
			MOD_MOTOR: begin
				desc.data = {hb_n[8], hb_n[9], hb_n[10], hb_n[11],
					hb_n[12], hb_n[13], hb_n[14], hb_n[15]};
				if (hb_n[5] == METH_CHASSIS && hb_n[7] >= CHASSIS_ID_LO
						&& hb_n[7] <= CHASSIS_ID_HI) begin
					dec_ok = 1'b1;
					desc.kind = KIND_CHASSIS;
					desc.unit = 3'(hb_n[7] - CHASSIS_ID_LO);
				end else if (hb_n[5] == METH_JOINT && hb_n[7] >= JOINT_ID_LO
						&& hb_n[7] <= JOINT_ID_HI) begin
					dec_ok = 1'b1;
					desc.kind = KIND_JOINT;
					desc.unit = 3'(hb_n[7] - JOINT_ID_LO);
				end
			end
			default: begin
				dec_ok = 1'b0;
			end
		endcase
	end

	assign push = accept && done && dec_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			prev_q <= 8'd0;
			count_q <= 8'd0;
			len_q <= 9'd14;
			for (int i = 0; i < HDR_DEPTH; i++) begin
				hb_q[i] <= 8'd0;
			end
		end else if (accept) begin
			in_frame_q <= in_frame_n;
			prev_q <= prev_n;
			count_q <= count_n;
			len_q <= len_n;
			hb_q <= hb_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sld_queue.sv =====
`default_nettype none

module sld_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  sld_pkg::frame_desc_t wr_desc,
	input  wire                  pop,
	output sld_pkg::frame_desc_t head,
	output sld_pkg::q_stat_t     stat
);
	import sld_pkg::*;

	frame_desc_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign head = mem_q[rd_ptr_q];
	assign stat.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sld_back.sv =====
`default_nettype none

module sld_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sld_pkg::frame_desc_t head,
	input  sld_pkg::q_stat_t     stat,
	output logic                 pop,
	output logic                 res_valid,
	input  wire                  res_stall,
	output logic [2:0]           kind,
	output logic [2:0]           unit,
	output logic signed [31:0]   value_a,
	output logic signed [31:0]   value_b,
	output logic                 last
);
	import sld_pkg::*;

	logic        valid_q;
	logic [1:0]  chan_q;
	logic [2:0]  kind_q;
	logic [2:0]  unit_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic        last_q;

	logic        load;
	logic        take;
	logic        last_c;
	logic [2:0]  unit_c;
	logic [31:0] a_c;
	logic [31:0] b_c;
	logic [15:0] word_c;

	always_comb begin
		load = !valid_q || !res_stall;
		take = load && !stat.empty;
		word_c = head.data[16 * (3 - int'(chan_q)) +: 16];
		unit_c = head.unit;
		a_c = {{16{head.data[15]}}, head.data[15:0]};
		b_c = 32'd0;
		last_c = 1'b1;
		case (head.kind)
			KIND_VOLT: begin
				a_c = {{16{head.data[15]}}, head.data[15:0]};
			end
			KIND_IO: begin
				a_c = {28'd0, head.data[3:0]};
			end
			KIND_ANALOG: begin
				a_c = {{16{word_c[15]}}, word_c};
				unit_c = {1'b0, chan_q};
				last_c = (chan_q == LAST_CHANNEL);
			end
			KIND_CHASSIS, KIND_JOINT: begin
				a_c = head.data[63:32];
				b_c = head.data[31:0];
			end
			default: begin
				a_c = 32'd0;
			end
		endcase
		pop = take && last_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			chan_q <= 2'd0;
		end else if (load) begin
			valid_q <= !stat.empty;
			if (take) begin
				chan_q <= last_c ? 2'd0 : chan_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= head.kind;
			unit_q <= unit_c;
			a_q <= a_c;
			b_q <= b_c;
			last_q <= last_c;
		end
	end

	assign res_valid = valid_q;
	assign kind = kind_q;
	assign unit = unit_q;
	assign value_a = a_q;
	assign value_b = b_q;
	assign last = last_q;

endmodule

`default_nettype wire
